@@ hdl/salted_fnv1_string_hash_assert.svh @@
// assertion macros for the salted fnv-1 string hash block
// expects clk and arst_n in the scope of each use
`ifndef SALTED_FNV1_STRING_HASH_ASSERT_SVH
`define SALTED_FNV1_STRING_HASH_ASSERT_SVH

// same-cycle implication, off while in reset
`define SFNV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfnv assertion failed");

// next-cycle implication, off while in reset
`define SFNV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfnv assertion failed");

`endif

@@ hdl/sfnv_pkg.sv @@
// constants and helpers for the salted fnv-1 string hash block
// no dependencies
`timescale 1ns / 1ps

package sfnv_pkg;

	localparam int unsigned HASH_W   = 32;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned BUCKET_W = 16;

	localparam logic [HASH_W-1:0] OFFSET_BASIS = 32'h811C_9DC5;

	// default fold point, legal range 8..16
	localparam int unsigned FOLD_BITS_DEF = 16;

	// ascii upper case range
	localparam logic [CHAR_W-1:0] UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

	function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= UPPER_A && c <= UPPER_Z) begin
			r = c + CASE_OFS;
		end
		return r;
	endfunction

	// multiply by the fnv prime 16777619 = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 2^0, mod 2^32
	function automatic logic [HASH_W-1:0] mul_prime(input logic [HASH_W-1:0] h);
		return h + (h << 1) + (h << 4) + (h << 7) + (h << 8) + (h << 24);
	endfunction

endpackage

@@ hdl/salted_fnv1_string_hash.sv @@
// salted fnv-1 string hash, folded to a bucket index; top level
// depends on sfnv_pkg and salted_fnv1_string_hash_assert.svh
`timescale 1ns / 1ps
//
// usage:
//   input channel (in_valid/in_ready): one word per character, char_byte plus
//   last, which marks the final character of a string
//   output channel (out_valid/out_ready): one word per string, the 16-bit bucket
//   config channel (cfg_valid/cfg_ready): writes the 32-bit salt, always ready;
//   write it only while no string is in flight
// path: an accepted word is registered in the input register; when it advances,
//   the hash register is updated and the bucket of a last word is registered
//   in the output register that drives out_valid
// throughput: one character per cycle while no last word waits; the path is the
//   shift-add prime multiply plus the character and salt xor, input reg to hash
// stall: the output register holds one bucket; while it waits, characters that
//   are not last keep flowing, a last word waits in the input register and
//   in_ready drops until the bucket is taken
// reset: running hash to the offset basis, salt to zero, both channels empty
//
`include "salted_fnv1_string_hash_assert.svh"

module salted_fnv1_string_hash #(
	parameter int unsigned FOLD_BITS = sfnv_pkg::FOLD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// character words
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sfnv_pkg::CHAR_W-1:0]     char_byte,
	input  logic                            last,
	// bucket words
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sfnv_pkg::BUCKET_W-1:0]   bucket,
	// salt register write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfnv_pkg::HASH_W-1:0]     salt
);

	// mask of the low FOLD_BITS bits for the fold
	localparam logic [sfnv_pkg::HASH_W-1:0] FOLD_MASK =
		(sfnv_pkg::HASH_W'(1) << FOLD_BITS) - sfnv_pkg::HASH_W'(1);

	// input register
	logic                            valid_s1;
	logic [sfnv_pkg::CHAR_W-1:0]     char_s1;
	logic                            last_s1;

	// state and result
	logic [sfnv_pkg::HASH_W-1:0]     salt_q;
	logic [sfnv_pkg::HASH_W-1:0]     hash_q;
	logic                            out_valid_q;
	logic [sfnv_pkg::BUCKET_W-1:0]   bucket_q;

	logic                            out_free;
	logic                            adv_s1;
	logic [sfnv_pkg::HASH_W-1:0]     hash_next;
	logic [sfnv_pkg::HASH_W-1:0]     fold_hi;
	logic [sfnv_pkg::HASH_W-1:0]     fold_lo;
	logic [sfnv_pkg::BUCKET_W-1:0]   bucket_next;

	assign cfg_ready = 1'b1;

	// output slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	// a non-last character never needs the output slot
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	// mix: multiply by prime, then xor in the lower-cased character and the salt; fold to the bucket
	always_comb begin
		hash_next = sfnv_pkg::mul_prime(hash_q)
			^ {{(sfnv_pkg::HASH_W-sfnv_pkg::CHAR_W){1'b0}}, sfnv_pkg::to_lower(char_s1)}
			^ salt_q;
		fold_hi     = hash_next >> FOLD_BITS;
		fold_lo     = hash_next & FOLD_MASK;
		bucket_next = fold_hi[sfnv_pkg::BUCKET_W-1:0] ^ fold_lo[sfnv_pkg::BUCKET_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			salt_q <= salt;
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_byte;
			last_s1 <= last;
		end
	end

	// running hash: back to the basis after the last character of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= sfnv_pkg::OFFSET_BASIS;
		end else if (adv_s1) begin
			hash_q <= last_s1 ? sfnv_pkg::OFFSET_BASIS : hash_next;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			bucket_q <= bucket_next;
		end
	end

	assign out_valid = out_valid_q;
	assign bucket    = bucket_q;

	// a finished string leaves a bucket pending and the hash at the basis
	`SFNV_ASSERT_NEXT(a_last_emits, adv_s1 && last_s1,
		out_valid && hash_q == sfnv_pkg::OFFSET_BASIS)
	// the input side only stalls behind a last word blocked by a full output
	`SFNV_ASSERT_NOW(a_stall_cause, !in_ready,
		valid_s1 && last_s1 && out_valid_q && !out_ready)
	// a mid-string character carries its mix into the running hash
	`SFNV_ASSERT_NEXT(a_mid_mix, adv_s1 && !last_s1, hash_q == $past(hash_next))

endmodule
